>>> sv/gpse_pkg.sv
package gpse_pkg;

   localparam int CSR_AW = 4;

   localparam logic [CSR_AW-1:0] CSR_DEVICE_MODE   = 4'h0;
   localparam logic [CSR_AW-1:0] CSR_RELATIVE_AXES = 4'h4;
   localparam logic [CSR_AW-1:0] CSR_TAP_SIGNATURE = 4'h8;

   localparam logic [2:0] MODE_PAD8      = 3'd0;
   localparam logic [2:0] MODE_TAP4      = 3'd1;
   localparam logic [2:0] MODE_TAP_ALT   = 3'd2;
   localparam logic [2:0] MODE_TRACKBALL = 3'd3;
   localparam logic [2:0] MODE_PAD16     = 3'd4;
   localparam logic [2:0] MODE_MOUSE     = 3'd5;

   localparam logic FUNC_LATCH = 1'b0;
   localparam logic FUNC_CLOCK = 1'b1;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic [2:0] device_mode;
      logic [1:0] relative_axes;
      logic [7:0] tap_signature;
   } cfg_type;

   typedef struct packed {
      logic              func;
      logic              latch_high;
      logic [7:0]        buttons_low;
      logic [7:0]        buttons_high;
      logic [7:0]        turbo_low;
      logic [7:0]        turbo_high;
      logic [7:0]        extra_pad;
      logic signed [15:0] first_axis;
      logic signed [15:0] second_axis;
   } req_type;

   typedef struct packed {
      logic [5:0] bit_count;
      logic [7:0] bit_select;
      logic [7:0] speed_code;
      logic       speed_pending;
      logic [7:0] axis_zero;
      logic [7:0] axis_one;
      logic [1:0] lines;
   } state_type;

   typedef struct packed {
      logic [1:0] lines;
      logic [1:0] consume;
   } rsp_type;

endpackage

>>> sv/gpse_step.sv
module gpse_step (
   input  gpse_pkg::cfg_type   cfg,
   input  gpse_pkg::state_type cur,
   input  gpse_pkg::req_type   req,
   output gpse_pkg::state_type nxt,
   output gpse_pkg::rsp_type   rsp
);

   function automatic logic [7:0] mouse_byte(input logic signed [15:0] v);
      logic signed [15:0] mag;
      logic [7:0]         b;
      mag = -v;
      if (v > 16'sd127) begin
         b = 8'h80;
      end else if (v < -16'sd127) begin
         b = 8'h00;
      end else if (v < 16'sd0) begin
         b = ~{1'b1, mag[6:0]};
      end else begin
         b = ~v[7:0];
      end
      return b;
   endfunction

   function automatic logic [3:0] ball_nibble(input logic signed [15:0] v);
      logic [3:0] n;
      if (v > 16'sd7) begin
         n = 4'h7;
      end else if (v < -16'sd8) begin
         n = 4'h8;
      end else begin
         n = v[3:0];
      end
      return n;
   endfunction

   logic [7:0] p0;
   logic [7:0] p1;
   logic [7:0] s;
   logic [2:0] idx;
   logic [7:0] speed_dec;
   logic       last_bit;

   assign p0        = req.buttons_low | req.turbo_low;
   assign p1        = req.buttons_high | req.turbo_high;
   assign s         = cur.bit_select;
   assign idx       = cur.bit_count[5:3];
   assign speed_dec = cur.speed_code - 8'h10;
   assign last_bit  = (s == 8'h01);

   always_comb begin
      nxt         = cur;
      rsp.consume = 2'b00;
      if (req.func == gpse_pkg::FUNC_LATCH) begin
         if (cfg.device_mode == gpse_pkg::MODE_TRACKBALL) begin
            nxt.lines[1] = req.buttons_low[7];
         end else begin
            if (cfg.device_mode == gpse_pkg::MODE_TAP_ALT) begin
               nxt.lines[1] = req.extra_pad[7];
            end
            nxt.lines[0] = p0[7];
         end
         nxt.bit_count  = 6'd1;
         nxt.bit_select = 8'h40;
      end else begin
         case (cfg.device_mode)
            gpse_pkg::MODE_PAD8: begin
               nxt.lines[0] = (idx == 3'd0) && |(p0 & s);
            end
            gpse_pkg::MODE_TAP4: begin
               case (idx)
                  3'd0:    nxt.lines[0] = |(p0 & s);
                  3'd1:    nxt.lines[0] = |(req.extra_pad & s);
                  3'd2:    nxt.lines[0] = |(cfg.tap_signature & s);
                  default: nxt.lines[0] = 1'b0;
               endcase
            end
            gpse_pkg::MODE_TAP_ALT: begin
               nxt.lines[0] = (idx == 3'd0) && |(p0 & s);
               nxt.lines[1] = (idx == 3'd0) && |(req.extra_pad & s);
            end
            gpse_pkg::MODE_TRACKBALL: begin
               case (idx)
                  3'd0: begin
                     nxt.lines[1] = |(req.buttons_low & s);
                     if (last_bit) begin
                        nxt.axis_zero = {ball_nibble(req.first_axis),
                                         ball_nibble(req.second_axis)};
                        rsp.consume   = cfg.relative_axes;
                     end
                  end
                  3'd1:    nxt.lines[1] = |(cur.axis_zero & s);
                  3'd2:    nxt.lines[1] = |(req.buttons_high & s);
                  default: nxt.lines[1] = 1'b0;
               endcase
            end
            gpse_pkg::MODE_PAD16: begin
               case (idx)
                  3'd0:    nxt.lines[0] = |(p0 & s);
                  3'd1:    nxt.lines[0] = |(p1 & s);
                  default: nxt.lines[0] = 1'b0;
               endcase
            end
            gpse_pkg::MODE_MOUSE: begin
               if (req.latch_high) begin
                  nxt.speed_pending = 1'b1;
               end else begin
                  case (idx)
                     3'd0: begin
                        nxt.lines[0] = |(req.buttons_low & s);
                        if (cur.speed_pending) begin
                           // step the speed code down, wrap to the slowest
                           nxt.speed_code    = (speed_dec < 8'hDF) ? 8'hFF : speed_dec;
                           nxt.speed_pending = 1'b0;
                        end
                     end
                     3'd1: begin
                        nxt.lines[0] = |(req.buttons_high & s & cur.speed_code);
                        if (last_bit) begin
                           nxt.axis_zero  = mouse_byte(req.first_axis);
                           rsp.consume[0] = cfg.relative_axes[0];
                        end
                     end
                     3'd2: begin
                        nxt.lines[0] = |(cur.axis_zero & s);
                        if (last_bit) begin
                           nxt.axis_one   = mouse_byte(req.second_axis);
                           rsp.consume[1] = cfg.relative_axes[1];
                        end
                     end
                     3'd3:    nxt.lines[0] = |(cur.axis_one & s);
                     default: nxt.lines[0] = 1'b0;
                  endcase
               end
            end
            default: begin
            end
         endcase
         if (cur.bit_count != 6'd63) begin
            nxt.bit_count = cur.bit_count + 6'd1;
         end
         nxt.bit_select = last_bit ? 8'h80 : (s >> 1);
      end
      rsp.lines = nxt.lines;
   end

endmodule

>>> sv/game_pad_port_shift_emulator.sv
// Controller port emulator for the console serial shift protocol. Each request
// is one latch or clock event (req_tuser: 0 latch, 1 clock); the block answers
// every request with one response holding both data line levels and the axis
// consume strobes. The event logic sits between the port state registers and
// the response register, so a new request is taken every cycle while the
// response register is empty or being drained. The response is registered
// and appears in the cycle after its request. Registers (APB): 0x0
// device_mode, 0x4 relative_axes, 0x8 tap_signature; write them only while idle.
module game_pad_port_shift_emulator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // latch_high, buttons_low, buttons_high, turbo_low, turbo_high, extra_pad,
   // first_axis, second_axis, zero fill
   input  logic [gpse_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // line_zero, line_one, consume_first, consume_second, zero fill
   output logic [gpse_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gpse_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   gpse_pkg::cfg_type   cfg_ff;
   gpse_pkg::cfg_type   cfg_in;
   gpse_pkg::state_type state_ff;
   gpse_pkg::state_type state_in;
   gpse_pkg::rsp_type   rsp_ff;
   gpse_pkg::rsp_type   rsp_in;
   gpse_pkg::req_type   req;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                req_fire;
   logic                csr_write;

   assign req.func         = req_tuser;
   assign req.latch_high   = req_tdata[0];
   assign req.buttons_low  = req_tdata[8:1];
   assign req.buttons_high = req_tdata[16:9];
   assign req.turbo_low    = req_tdata[24:17];
   assign req.turbo_high   = req_tdata[32:25];
   assign req.extra_pad    = req_tdata[40:33];
   assign req.first_axis   = req_tdata[56:41];
   assign req.second_axis  = req_tdata[72:57];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   gpse_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff           <= 1'b0;
         state_ff.bit_count     <= 6'd0;
         state_ff.bit_select    <= 8'h80;
         state_ff.speed_code    <= 8'hFF;
         state_ff.speed_pending <= 1'b0;
         state_ff.axis_zero     <= 8'h00;
         state_ff.axis_one      <= 8'h00;
         state_ff.lines         <= 2'b11;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.consume[1], rsp_ff.consume[0],
                        rsp_ff.lines[1], rsp_ff.lines[0]};

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr)
            gpse_pkg::CSR_DEVICE_MODE:   cfg_in.device_mode   = csr_pwdata[2:0];
            gpse_pkg::CSR_RELATIVE_AXES: cfg_in.relative_axes = csr_pwdata[1:0];
            gpse_pkg::CSR_TAP_SIGNATURE: cfg_in.tap_signature = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_mode   <= gpse_pkg::MODE_PAD8;
         cfg_ff.relative_axes <= 2'b11;
         cfg_ff.tap_signature <= 8'hEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr)
         gpse_pkg::CSR_DEVICE_MODE:   csr_prdata = {29'd0, cfg_ff.device_mode};
         gpse_pkg::CSR_RELATIVE_AXES: csr_prdata = {30'd0, cfg_ff.relative_axes};
         gpse_pkg::CSR_TAP_SIGNATURE: csr_prdata = {24'd0, cfg_ff.tap_signature};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   a_latch_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == gpse_pkg::FUNC_LATCH
      |=> state_ff.bit_count == 6'd1 && state_ff.bit_select == 8'h40)
      else $error("latch did not restart the bit counter");

   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.bit_select))
      else $error("bit selector lost its single bit");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.speed_code >= 8'hDF)
      else $error("speed code left its cycle");

   a_consume_modes: assert property (@(posedge clock) disable iff (reset)
      req_fire && cfg_ff.device_mode != gpse_pkg::MODE_TRACKBALL
      && cfg_ff.device_mode != gpse_pkg::MODE_MOUSE
      |=> rsp_ff.consume == 2'b00)
      else $error("consume strobe in a mode without axes");

endmodule
